// ===== src/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants for the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_R1,
        PH_R2,
        PH_DONE
    } t_phase;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SMUL,
        B_SFIN,
        B_EMUL,
        B_RND,
        B_EMIT,
        B_NOTE,
        B_UPD1,
        B_UPD2
    } t_bstate;

    typedef struct packed {
        logic avail;
        t_op  op;
    } t_cmd_ctl;

    typedef struct packed {
        logic valid;
        logic last;
        logic done;
    } t_res_flags;

    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 2;

    localparam logic [2:0] SMUL_LAST = 3'd2;
    localparam logic [2:0] EMUL_LAST = 3'd5;
    localparam logic [1:0] EMIT_LAST = 2'd3;

endpackage

// ===== src/mer_front.sv =====
// ----------------------------------------------------------------------------
// mer_front
// Command queue: accepts items, decodes the opcode and holds them for the core.
// ----------------------------------------------------------------------------
module mer_front #(
    parameter int AXIS_BITS  = 11,
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_opcode,
    input  logic signed [COORD_BITS-1:0]  i_center_x,
    input  logic signed [COORD_BITS-1:0]  i_center_y,
    input  logic        [AXIS_BITS-1:0]   i_radius_x,
    input  logic        [AXIS_BITS-1:0]   i_radius_y,
    input  logic                          i_pop,
    output mer_pkg::t_cmd_ctl             o_ctl,
    output logic signed [COORD_BITS-1:0]  o_cx,
    output logic signed [COORD_BITS-1:0]  o_cy,
    output logic        [AXIS_BITS-1:0]   o_rx,
    output logic        [AXIS_BITS-1:0]   o_ry
);
    import mer_pkg::*;

    localparam int AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_op                         r_mop [CMDQ_DEPTH];
    logic signed [COORD_BITS-1:0] r_mcx [CMDQ_DEPTH];
    logic signed [COORD_BITS-1:0] r_mcy [CMDQ_DEPTH];
    logic        [AXIS_BITS-1:0]  r_mrx [CMDQ_DEPTH];
    logic        [AXIS_BITS-1:0]  r_mry [CMDQ_DEPTH];

    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_wen;
    logic          w_ren;
    t_op           w_op;

    assign o_full = (r_cnt == CW'(CMDQ_DEPTH));
    assign w_wen  = i_push && !o_full;
    assign w_ren  = i_pop && (r_cnt != '0);
    assign w_op   = i_opcode ? OP_STEP : OP_START;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_cnt = r_cnt;
        if (w_wen) begin
            n_wr = (r_wr == AW'(CMDQ_DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (w_ren) begin
            n_rd = (r_rd == AW'(CMDQ_DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (w_wen && !w_ren) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!w_wen && w_ren) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mop[r_wr] <= w_op;
            r_mcx[r_wr] <= i_center_x;
            r_mcy[r_wr] <= i_center_y;
            r_mrx[r_wr] <= i_radius_x;
            r_mry[r_wr] <= i_radius_y;
        end
    end

    assign o_ctl.avail = (r_cnt != '0);
    assign o_ctl.op    = r_mop[r_rd];
    assign o_cx        = r_mcx[r_rd];
    assign o_cy        = r_mcy[r_rd];
    assign o_rx        = r_mrx[r_rd];
    assign o_ry        = r_mry[r_rd];

endmodule

// ===== src/mer_outq.sv =====
// ----------------------------------------------------------------------------
// mer_outq
// Result queue between the core and the output port.
// ----------------------------------------------------------------------------
module mer_outq #(
    parameter int PXW = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic signed [PXW-1:0]  i_x,
    input  logic signed [PXW-1:0]  i_y,
    input  mer_pkg::t_res_flags    i_flags,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic signed [PXW-1:0]  o_x,
    output logic signed [PXW-1:0]  o_y,
    output mer_pkg::t_res_flags    o_flags
);
    import mer_pkg::*;

    localparam int AW = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
    localparam int CW = $clog2(OUTQ_DEPTH + 1);

    logic signed [PXW-1:0] r_mx [OUTQ_DEPTH];
    logic signed [PXW-1:0] r_my [OUTQ_DEPTH];
    t_res_flags            r_mf [OUTQ_DEPTH];

    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_wen;
    logic          w_ren;

    assign o_full  = (r_cnt == CW'(OUTQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wen   = i_push && !o_full;
    assign w_ren   = i_pop && !o_empty;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_cnt = r_cnt;
        if (w_wen) begin
            n_wr = (r_wr == AW'(OUTQ_DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (w_ren) begin
            n_rd = (r_rd == AW'(OUTQ_DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (w_wen && !w_ren) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!w_wen && w_ren) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mx[r_wr] <= i_x;
            r_my[r_wr] <= i_y;
            r_mf[r_wr] <= i_flags;
        end
    end

    assign o_x     = r_mx[r_rd];
    assign o_y     = r_my[r_rd];
    assign o_flags = r_mf[r_rd];

endmodule

// ===== src/mer_core.sv =====
// ----------------------------------------------------------------------------
// mer_core
// Back end: setup and region-2 multiplies, mirrored pixel emission, status items and decision update.
// ----------------------------------------------------------------------------
module mer_core #(
    parameter int AXIS_BITS  = 11,
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mer_pkg::t_cmd_ctl              i_cmd,
    input  logic signed [COORD_BITS-1:0]   i_cx,
    input  logic signed [COORD_BITS-1:0]   i_cy,
    input  logic        [AXIS_BITS-1:0]    i_rx,
    input  logic        [AXIS_BITS-1:0]    i_ry,
    output logic                           o_cmd_pop,
    input  logic                           i_res_full,
    output logic                           o_res_push,
    output logic signed [COORD_BITS:0]     o_res_x,
    output logic signed [COORD_BITS:0]     o_res_y,
    output mer_pkg::t_res_flags            o_res_flags
);
    import mer_pkg::*;

    localparam int A       = AXIS_BITS;
    localparam int XW      = A + 2;
    localparam int MW      = 2 * A + 6;
    localparam int DW_FULL = 4 * A + 6;
    localparam int DW      = (DW_FULL > 64) ? 64 : DW_FULL;
    localparam int PXW     = COORD_BITS + 1;
    localparam int PW      = (PXW > XW) ? PXW : XW;

    t_bstate r_st, n_st;
    t_phase  r_ph;
    t_phase  r_ph_after;

    logic [2:0] r_k;
    logic [1:0] r_cnt;
    logic       r_br;

    logic signed [COORD_BITS-1:0] r_cx, r_cy;
    logic        [A-1:0]          r_rx, r_ry;
    logic        [2*A-1:0]        r_rx2, r_ry2;
    logic signed [XW-1:0]         r_x, r_y;
    logic signed [DW-1:0]         r_xt, r_yt, r_d, r_q, r_acc;
    logic        [MW-1:0]         r_t1, r_t2;
    logic        [2*MW-1:0]       r_prod;

    logic        [MW-1:0]   w_ma, w_mb;
    logic        [2*MW-1:0] w_mul;
    logic signed [DW-1:0]   w_pd;
    logic signed [DW-1:0]   w_rx2d, w_ry2d;
    logic signed [DW-1:0]   w_rnd;
    logic signed [XW:0]     w_ym;
    logic        [XW:0]     w_ymag;
    logic        [MW-1:0]   w_xx;
    logic                   w_cross;
    logic                   w_start;
    logic signed [PW-1:0]   w_xe, w_ye, w_cxe, w_cye;
    logic signed [PW-1:0]   w_xp, w_xm, w_yp, w_ym2;

    assign w_pd    = signed'(r_prod[DW-1:0]);
    assign w_rx2d  = signed'(DW'(r_rx2));
    assign w_ry2d  = signed'(DW'(r_ry2));
    assign w_rnd   = (r_q + (r_q[DW-1] ? DW'(1) : DW'(2))) >>> 2;
    assign w_ym    = (XW+1)'(r_y) - (XW+1)'(1);
    assign w_ymag  = w_ym[XW] ? unsigned'(-w_ym) : unsigned'(w_ym);
    assign w_xx    = (MW'(unsigned'(r_x)) << 1) | MW'(1);
    assign w_cross = (r_xt > r_yt);
    assign w_start = (i_cmd.op == OP_START);
    assign w_mul   = w_ma * w_mb;

    assign w_xe  = PW'(r_x);
    assign w_ye  = PW'(r_y);
    assign w_cxe = PW'(r_cx);
    assign w_cye = PW'(r_cy);
    assign w_xp  = w_cxe + w_xe;
    assign w_xm  = w_cxe - w_xe;
    assign w_yp  = w_cye + w_ye;
    assign w_ym2 = w_cye - w_ye;

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            B_IDLE: begin
                if (i_cmd.avail) begin
                    if (w_start) begin
                        n_st = B_SMUL;
                    end else if (r_ph == PH_IDLE || r_ph == PH_DONE) begin
                        n_st = B_NOTE;
                    end else begin
                        n_st = B_EMIT;
                    end
                end
            end
            B_SMUL: begin
                if (r_k == SMUL_LAST) n_st = B_SFIN;
            end
            B_SFIN: n_st = B_RND;
            B_EMUL: begin
                if (r_k == EMUL_LAST) n_st = B_RND;
            end
            B_RND:  n_st = B_IDLE;
            B_EMIT: begin
                if (!i_res_full && r_cnt == EMIT_LAST) n_st = B_UPD1;
            end
            B_NOTE: begin
                if (!i_res_full) n_st = B_IDLE;
            end
            B_UPD1: n_st = B_UPD2;
            B_UPD2: begin
                if (r_ph == PH_R1 && (w_cross || r_y[XW-1])) begin
                    n_st = B_EMUL;
                end else begin
                    n_st = B_IDLE;
                end
            end
            default: n_st = B_IDLE;
        endcase
    end

    // outputs and multiplier operands
    always_comb begin
        o_cmd_pop   = (r_st == B_IDLE) && i_cmd.avail;
        o_res_push  = 1'b0;
        o_res_x     = '0;
        o_res_y     = '0;
        o_res_flags = '0;
        w_ma        = '0;
        w_mb        = '0;
        unique case (r_st)
            B_SMUL: begin
                unique case (r_k)
                    3'd0:    begin w_ma = MW'(r_rx);  w_mb = MW'(r_rx); end
                    3'd1:    begin w_ma = MW'(r_ry);  w_mb = MW'(r_ry); end
                    default: begin w_ma = MW'(r_rx2); w_mb = MW'(r_ry); end
                endcase
            end
            B_EMUL: begin
                unique case (r_k)
                    3'd0:    begin w_ma = w_xx;         w_mb = w_xx;         end
                    3'd1:    begin w_ma = MW'(w_ymag);  w_mb = MW'(w_ymag);  end
                    3'd2:    begin w_ma = MW'(r_ry2);   w_mb = r_t1;         end
                    3'd3:    begin w_ma = MW'(r_rx2);   w_mb = r_t2;         end
                    default: begin w_ma = MW'(r_rx2);   w_mb = MW'(r_ry2);   end
                endcase
            end
            B_EMIT: begin
                o_res_push        = !i_res_full;
                o_res_flags.valid = 1'b1;
                o_res_flags.last  = (r_cnt == EMIT_LAST);
                unique case (r_cnt)
                    2'd0:    begin o_res_x = w_xp[PXW-1:0]; o_res_y = w_yp[PXW-1:0];  end
                    2'd1:    begin o_res_x = w_xm[PXW-1:0]; o_res_y = w_ym2[PXW-1:0]; end
                    2'd2:    begin o_res_x = w_xp[PXW-1:0]; o_res_y = w_ym2[PXW-1:0]; end
                    default: begin o_res_x = w_xm[PXW-1:0]; o_res_y = w_yp[PXW-1:0];  end
                endcase
            end
            B_NOTE: begin
                o_res_push       = !i_res_full;
                o_res_flags.last = 1'b1;
                o_res_flags.done = (r_ph == PH_DONE);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= B_IDLE;
            r_ph <= PH_IDLE;
        end else begin
            r_st <= n_st;
            if (r_st == B_RND) begin
                r_ph <= r_ph_after;
            end else if (r_st == B_UPD2 && r_ph == PH_R2 && r_y[XW-1]) begin
                r_ph <= PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul;
        unique case (r_st)
            B_IDLE: begin
                r_k   <= '0;
                r_cnt <= '0;
                if (o_cmd_pop && w_start) begin
                    r_cx <= i_cx;
                    r_cy <= i_cy;
                    r_rx <= i_rx;
                    r_ry <= i_ry;
                end
            end
            B_SMUL: begin
                r_k <= r_k + 3'd1;
                if (r_k == 3'd1) r_rx2 <= r_prod[2*A-1:0];
                if (r_k == 3'd2) r_ry2 <= r_prod[2*A-1:0];
            end
            B_SFIN: begin
                r_q        <= (w_ry2d <<< 2) - (w_pd <<< 2) + w_rx2d;
                r_yt       <= w_pd <<< 1;
                r_xt       <= '0;
                r_x        <= '0;
                r_y        <= signed'(XW'(r_ry));
                r_ph_after <= PH_R1;
            end
            B_EMUL: begin
                r_k <= r_k + 3'd1;
                unique case (r_k)
                    3'd1: r_t1 <= r_prod[MW-1:0];
                    3'd2: r_t2 <= r_prod[MW-1:0];
                    3'd3: r_acc <= w_pd;
                    3'd4: r_acc <= r_acc + (w_pd <<< 2);
                    3'd5: begin
                        r_q        <= r_acc - (w_pd <<< 2);
                        r_ph_after <= r_y[XW-1] ? PH_DONE : PH_R2;
                    end
                    default: begin
                    end
                endcase
            end
            B_RND: begin
                r_d <= w_rnd;
            end
            B_EMIT: begin
                if (!i_res_full) r_cnt <= r_cnt + 2'd1;
            end
            B_UPD1: begin
                if (r_ph == PH_R1) begin
                    r_x  <= r_x + XW'(1);
                    r_xt <= r_xt + (w_ry2d <<< 1);
                    r_br <= r_d[DW-1];
                    if (!r_d[DW-1]) begin
                        r_y  <= r_y - XW'(1);
                        r_yt <= r_yt - (w_rx2d <<< 1);
                    end
                end else begin
                    r_y  <= r_y - XW'(1);
                    r_yt <= r_yt - (w_rx2d <<< 1);
                    r_br <= (r_d != '0) && !r_d[DW-1];
                    if (r_d == '0 || r_d[DW-1]) begin
                        r_x  <= r_x + XW'(1);
                        r_xt <= r_xt + (w_ry2d <<< 1);
                    end
                end
            end
            B_UPD2: begin
                r_k <= '0;
                if (r_ph == PH_R1) begin
                    r_d <= r_d + w_ry2d + r_xt - (r_br ? DW'(0) : r_yt);
                end else begin
                    r_d <= r_d + w_rx2d - r_yt + (r_br ? DW'(0) : r_xt);
                end
            end
            default: begin
            end
        endcase
    end

    a_push_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (r_st == B_EMIT || r_st == B_NOTE))
        else $error("result pushed outside emit or status state");

    a_last_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && r_st == B_EMIT) |-> (o_res_flags.last == (r_cnt == EMIT_LAST)))
        else $error("last flag not on fourth pixel");

    a_start_r1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == B_SFIN) |=> (r_st == B_RND && r_ph_after == PH_R1))
        else $error("start setup did not enter region 1");

    a_y_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == B_IDLE && (r_ph == PH_R1 || r_ph == PH_R2)) |-> !r_y[XW-1])
        else $error("tracing phase with negative y");

    a_smul_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == B_SMUL) |-> (r_k <= SMUL_LAST))
        else $error("setup multiply counter out of range");

endmodule

// ===== src/midpoint_ellipse_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Two-region midpoint ellipse rasterizer with queue-style ports.
// ----------------------------------------------------------------------------
// Input channel: push/full. Opcode start loads centre and semi-axes and gives
// no result; opcode step traces one point and gives four mirrored pixels, the
// fourth marked last. A step before any start, or after the curve is done,
// gives one status item with last set (and curve_done set after completion).
// Result channel: empty/pop; the oldest result is on the ports while empty is
// low. Items are held in a two-entry command queue and a two-entry result
// queue, so the core runs on while the receiver stalls, until the result
// queue fills; the core then waits with no loss.
// Sequence per item, set by the core sequencer and its single multiplier:
//   start: 3 multiplies, combine, rounding
//   step: pop, 4 pixels at one per cycle while the result queue has room,
//         a decision update in UPD1 then UPD2, and on the step that moves
//         into region 2 also 5 multiplies and rounding
//   status step: pop, then one status item once the result queue has room
// Reset (synchronous, active low) empties both queues and returns to idle.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer #(
    parameter int AXIS_BITS  = 11,
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_opcode,
    input  logic signed [COORD_BITS-1:0]  i_center_x,
    input  logic signed [COORD_BITS-1:0]  i_center_y,
    input  logic        [AXIS_BITS-1:0]   i_radius_x,
    input  logic        [AXIS_BITS-1:0]   i_radius_y,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [COORD_BITS:0]    o_pixel_x,
    output logic signed [COORD_BITS:0]    o_pixel_y,
    output logic                          o_pixel_valid,
    output logic                          o_last_of_step,
    output logic                          o_curve_done
);
    import mer_pkg::*;

    t_cmd_ctl                     w_cmd;
    logic signed [COORD_BITS-1:0] w_cx, w_cy;
    logic        [AXIS_BITS-1:0]  w_rx, w_ry;
    logic                         w_cmd_pop;
    logic                         w_res_full;
    logic                         w_res_push;
    logic signed [COORD_BITS:0]   w_res_x, w_res_y;
    t_res_flags                   w_res_flags;
    t_res_flags                   w_out_flags;

    mer_front #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_opcode   (i_opcode),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius_x (i_radius_x),
        .i_radius_y (i_radius_y),
        .i_pop      (w_cmd_pop),
        .o_ctl      (w_cmd),
        .o_cx       (w_cx),
        .o_cy       (w_cy),
        .o_rx       (w_rx),
        .o_ry       (w_ry)
    );

    mer_core #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cx        (w_cx),
        .i_cy        (w_cy),
        .i_rx        (w_rx),
        .i_ry        (w_ry),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res_x     (w_res_x),
        .o_res_y     (w_res_y),
        .o_res_flags (w_res_flags)
    );

    mer_outq #(
        .PXW (COORD_BITS + 1)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .o_full  (w_res_full),
        .i_x     (w_res_x),
        .i_y     (w_res_y),
        .i_flags (w_res_flags),
        .i_pop   (pop),
        .o_empty (empty),
        .o_x     (o_pixel_x),
        .o_y     (o_pixel_y),
        .o_flags (w_out_flags)
    );

    assign o_pixel_valid  = w_out_flags.valid;
    assign o_last_of_step = w_out_flags.last;
    assign o_curve_done   = w_out_flags.done;

endmodule
